[design/rau_pkg.sv]
// Package for the rational arithmetic unit: widths, command codes and queue entry type.
// No dependencies; used by every module of the block.
package rau_pkg;
   localparam int OPW = 32;
   localparam int NUMW = 64;
   localparam int DENW = 62;
   localparam int QDEPTH = 2;
   localparam int QAW = 1;

   localparam logic [1:0] CMD_NORM = 2'd0;
   localparam logic [1:0] CMD_ADD  = 2'd1;
   localparam logic [1:0] CMD_ADDI = 2'd2;
   localparam logic [1:0] CMD_MUL  = 2'd3;

   typedef struct packed {
      logic [1:0]            cmd;
      logic                  ok;
      logic signed [OPW-1:0] an;
      logic signed [OPW-1:0] ad;
      logic signed [OPW-1:0] bn;
      logic signed [OPW-1:0] bd;
   } job_type;

   typedef struct packed {
      logic            valid;
      logic [NUMW-1:0] num;
      logic [DENW-1:0] den;
   } res_type;
endpackage

[design/rau_front.sv]
// Front end: accepts request transactions, checks operands, queues jobs.
// Depends on rau_pkg.
module rau_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  logic [1:0]      cmd,
   input  logic            a_valid,
   input  logic [rau_pkg::OPW-1:0] a_num,
   input  logic [rau_pkg::OPW-1:0] a_den,
   input  logic            b_valid,
   input  logic [rau_pkg::OPW-1:0] b_num,
   input  logic [rau_pkg::OPW-1:0] b_den,
   output logic            job_valid,
   input  logic            job_ready,
   output rau_pkg::job_type job
);
   import rau_pkg::*;
   job_type q_ff [QDEPTH];
   logic [QAW-1:0] wp_ff, rp_ff, wp_in, rp_in;
   logic [QAW:0] cnt_ff, cnt_in;
   logic signed [OPW-1:0] an, ad, bn, bd;
   logic a_ok, b_ok, ok, push, pop;
   job_type nj;

   always_comb begin
      an = a_num; ad = a_den; bn = b_num; bd = b_den;
      a_ok = a_valid && an != -1 && ad > 0;
      b_ok = b_valid && bn != -1 && bd > 0;
      case (cmd)
         CMD_NORM: ok = an >= 0 && ad > 0;
         CMD_ADDI: ok = a_ok && bn != -1;
         default:  ok = a_ok && b_ok;
      endcase
      nj = '{cmd: cmd, ok: ok, an: an, ad: ad, bn: bn, bd: bd};
   end

   assign in_ready  = cnt_ff != QAW'(0) + (QAW+1)'(QDEPTH);
   assign push      = in_valid && in_ready;
   assign job_valid = cnt_ff != '0;
   assign pop       = job_valid && job_ready;
   assign job       = q_ff[rp_ff];
   assign wp_in     = push ? wp_ff + 1'b1 : wp_ff;
   assign rp_in     = pop ? rp_ff + 1'b1 : rp_ff;
   assign cnt_in    = cnt_ff + (QAW+1)'(push) - (QAW+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
      if (push) q_ff[wp_ff] <= nj;
   end
endmodule

[design/rau_back.sv]
// Back end: runs one job at a time; for normalize, GCD by Euclid's algorithm over a
// one-bit-per-cycle restoring divider, then two divisions by the GCD. Depends on rau_pkg.
module rau_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_ready,
   input  rau_pkg::job_type job,
   output logic             out_valid,
   input  logic             out_ready,
   output rau_pkg::res_type res
);
   import rau_pkg::*;
   localparam logic [2:0] S_IDLE = 3'd0, S_MUL1 = 3'd1, S_MUL2 = 3'd2, S_GCD = 3'd3,
                          S_DIVN = 3'd4, S_DIVD = 3'd5, S_OUT = 3'd6;
   localparam int CW = $clog2(OPW+1);
   logic [2:0] st_ff, st_in;
   job_type j_ff;
   logic signed [NUMW-1:0] p1_ff, p2_ff, p3_ff;
   logic [OPW-1:0] y_ff, r_ff, qt_ff, dv_ff, g_ff;
   logic [CW-1:0] c_ff;
   logic [OPW-1:0] nq_ff;
   res_type r_out_ff;
   logic [OPW:0] trial;
   logic [OPW-1:0] rsh;
   logic signed [NUMW-1:0] num;
   logic signed [NUMW-1:0] den;

   assign job_ready = st_ff == S_IDLE;
   assign out_valid = st_ff == S_OUT;
   assign res = r_out_ff;
   assign rsh = {r_ff[OPW-2:0], dv_ff[OPW-1]};
   assign trial = {1'b0, rsh} - {1'b0, (st_ff == S_GCD) ? y_ff : g_ff};

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         S_IDLE: if (job_valid) st_in = S_MUL1;
         S_MUL1: begin
            if (j_ff.cmd == CMD_NORM && j_ff.ok && j_ff.an != 0) st_in = S_GCD;
            else st_in = S_MUL2;
         end
         S_MUL2: st_in = S_OUT;
         S_GCD:  if (c_ff == '0 && r_ff == '0) st_in = S_DIVN;
         S_DIVN: if (c_ff == '0) st_in = S_DIVD;
         S_DIVD: if (c_ff == '0) st_in = S_OUT;
         S_OUT:  if (out_ready) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= S_IDLE;
      else begin
         st_ff <= st_in;
         unique case (st_ff)
            S_IDLE: ;
            S_MUL1: if (j_ff.cmd == CMD_NORM && j_ff.ok && j_ff.an != 0) begin
               y_ff <= j_ff.ad;
               dv_ff <= j_ff.an; r_ff <= '0; c_ff <= CW'(OPW);
            end
            S_MUL2: ;
            S_GCD: begin
               if (c_ff != '0) begin
                  r_ff <= trial[OPW] ? rsh : trial[OPW-1:0];
                  dv_ff <= {dv_ff[OPW-2:0], 1'b0};
                  c_ff <= c_ff - 1'b1;
               end else if (r_ff == '0) begin
                  g_ff <= y_ff; dv_ff <= j_ff.an; r_ff <= '0;
                  c_ff <= CW'(OPW);
               end else begin
                  y_ff <= r_ff; dv_ff <= y_ff; r_ff <= '0;
                  c_ff <= CW'(OPW);
               end
            end
            S_DIVN, S_DIVD: begin
               if (c_ff != '0) begin
                  r_ff <= trial[OPW] ? rsh : trial[OPW-1:0];
                  qt_ff <= {qt_ff[OPW-2:0], ~trial[OPW]};
                  dv_ff <= {dv_ff[OPW-2:0], 1'b0};
                  c_ff <= c_ff - 1'b1;
               end else if (st_ff == S_DIVN) begin
                  nq_ff <= qt_ff; dv_ff <= j_ff.ad; r_ff <= '0;
                  c_ff <= CW'(OPW);
               end else begin
                  r_out_ff <= '{valid: nq_ff != '1, num: NUMW'(nq_ff),
                                den: DENW'(qt_ff)};
               end
            end
            S_OUT: ;
            default: ;
         endcase
      end
      if (st_ff == S_IDLE && job_valid) j_ff <= job;
      if (st_ff == S_MUL1) begin
         p1_ff <= NUMW'(j_ff.an) * NUMW'((j_ff.cmd == CMD_MUL) ? j_ff.bn : j_ff.bd);
         p2_ff <= NUMW'(j_ff.bn) * NUMW'(j_ff.ad);
         p3_ff <= NUMW'(j_ff.ad) * NUMW'(j_ff.bd);
      end
      if (st_ff == S_MUL2) r_out_ff <= (j_ff.ok && num != -1) ?
         '{valid: 1'b1, num: num, den: DENW'(den)} : '0;
   end

   always_comb begin
      unique case (j_ff.cmd)
         CMD_NORM: begin num = '0; den = NUMW'(j_ff.ad); end
         CMD_ADD:  begin num = p1_ff + p2_ff; den = p3_ff; end
         CMD_ADDI: begin num = NUMW'(j_ff.an) + p2_ff; den = NUMW'(j_ff.ad); end
         default:  begin num = p1_ff; den = p3_ff; end
      endcase
   end
endmodule

[design/rational_arith_unit_top.sv]
// Top level of the rational arithmetic unit: front end, job queue, back end.
// Depends on rau_pkg, rau_front, rau_back.
// channel | dir | tdata fields (low first)                       | tuser
// req     | in  | cmd,a_valid,a_num,a_den,b_valid,b_num,b_den    | -
// rsp     | out | res_valid,res_num,res_den                      | -
// Add, add-integer, multiply: the back end forms the products, then registers the result.
// Normalize, positive numerator: one division per Euclid step (up to about 45 steps on
// 31-bit operands), then two divisions by the GCD, on the one-bit-per-cycle divider.
// Synchronous reset empties the two-entry job queue; either side may stall freely.
module rational_arith_unit_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [135:0] req_tdata,  // cmd, a_valid, a_num, a_den, b_valid, b_num, b_den
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata   // res_valid, res_num, res_den
);
   import rau_pkg::*;
   logic jv, jr;
   job_type job;
   res_type res;

   rau_front u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .cmd(req_tdata[1:0]), .a_valid(req_tdata[2]), .a_num(req_tdata[34:3]),
      .a_den(req_tdata[66:35]), .b_valid(req_tdata[67]), .b_num(req_tdata[99:68]),
      .b_den(req_tdata[131:100]), .job_valid(jv), .job_ready(jr), .job(job));

   rau_back u_back (
      .clock, .reset, .job_valid(jv), .job_ready(jr), .job(job),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .res(res));

   assign rsp_tdata = {1'b0, res.den, res.num, res.valid};

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)) else $error("rsp hold");
   a_inv: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[126:1] == '0) else $error("invalid not zero");
   a_den: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[126:65] != '0) else $error("zero den");
endmodule

[sim/rational_arith_unit_top_test.sv]
`timescale 1ns / 100ps
// Self-checking bench for rational_arith_unit_top: directed table, then random
// transactions checked by a local predictor. Depends on rau_pkg and the block RTL.
module rational_arith_unit_top_test;
   import rau_pkg::*;

   typedef struct {
      logic [1:0]  cmd;
      logic        av;
      logic [31:0] an;
      logic [31:0] ad;
      logic        bv;
      logic [31:0] bn;
      logic [31:0] bd;
      bit          typed;
      res_type     want;
   } fraction_op;

   localparam logic [31:0] MAXV = 32'h7fff_ffff;
   localparam logic [31:0] MINV = 32'h8000_0000;
   localparam logic [31:0] NEG1 = 32'hffff_ffff;
   localparam res_type EMPTY = '{valid: 1'b0, num: '0, den: '0};

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;   // cmd, a_valid, a_num, a_den, b_valid, b_num, b_den
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;        // res_valid, res_num, res_den

   res_type     pending_results[$];
   res_type     next_want;
   int          failures = 0;
   int          sender_idle_pct = 0;
   int          stall_pct = 0;
   int          cmd_count[4] = '{0, 0, 0, 0};
   int          empty_count = 0;
   int          result_count = 0;

   rational_arith_unit_top u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic res_type rational_result(fraction_op op);
      longint an, ad, bn, bd, num, den;
      longint unsigned x, y, t;
      bit a_ok, b_ok, ok;
      res_type r;
      an = longint'($signed(op.an));
      ad = longint'($signed(op.ad));
      bn = longint'($signed(op.bn));
      bd = longint'($signed(op.bd));
      a_ok = op.av && an != -1 && ad > 0;
      b_ok = op.bv && bn != -1 && bd > 0;
      ok = 1'b1;
      num = 0;
      den = 0;
      case (op.cmd)
         CMD_NORM: begin
            if (an < 0 || ad <= 0) begin
               ok = 1'b0;
            end else if (an == 0) begin
               den = ad;
            end else begin
               x = an;
               y = ad;
               while (y != 0) begin
                  t = x % y;
                  x = y;
                  y = t;
               end
               num = an / longint'(x);
               den = ad / longint'(x);
            end
         end
         CMD_ADD: begin
            ok = a_ok && b_ok;
            num = an * bd + bn * ad;
            den = ad * bd;
         end
         CMD_ADDI: begin
            ok = a_ok && bn != -1;
            num = an + bn * ad;
            den = ad;
         end
         default: begin
            ok = a_ok && b_ok;
            num = an * bn;
            den = ad * bd;
         end
      endcase
      if (!ok || num == -1) return EMPTY;
      r.valid = 1'b1;
      r.num = num;
      r.den = den[DENW-1:0];
      return r;
   endfunction

   // Book expectations on accepted requests, check accepted responses.
   always @(posedge clock) begin
      res_type got, exp_r;
      if (!reset) begin
         if (req_tvalid && req_tready) pending_results.push_back(next_want);
         if (rsp_tvalid && rsp_tready) begin
            got.valid = rsp_tdata[0];
            got.num = rsp_tdata[64:1];
            got.den = rsp_tdata[126:65];
            result_count++;
            if (!got.valid) empty_count++;
            if (pending_results.size() == 0) begin
               $error("unexpected response valid=%0b num=%0d den=%0d",
                  got.valid, $signed(got.num), got.den);
               failures++;
            end else begin
               exp_r = pending_results.pop_front();
               if (got.valid !== exp_r.valid) begin
                  $error("res_valid expected %0b got %0b", exp_r.valid, got.valid);
                  failures++;
               end
               if (got.num !== exp_r.num) begin
                  $error("res_num expected %0d got %0d", $signed(exp_r.num),
                     $signed(got.num));
                  failures++;
               end
               if (got.den !== exp_r.den) begin
                  $error("res_den expected %0d got %0d", exp_r.den, got.den);
                  failures++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic send_op(fraction_op op);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      end
      cmd_count[op.cmd]++;
      next_want <= op.typed ? op.want : rational_result(op);
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0, op.bd, op.bn, op.bv, op.ad, op.an, op.av, op.cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value(bit narrow);
      case ($urandom_range(9))
         0: return MAXV;
         1: return MINV;
         2: return NEG1;
         3, 4: return $urandom_range(40);
         5: return narrow ? $urandom_range(40) : $urandom();
         default: return narrow ? $urandom_range(65535) : $urandom();
      endcase
   endfunction

   function automatic fraction_op random_op();
      fraction_op op;
      bit narrow;
      op.cmd = 2'($urandom_range(3));
      narrow = (op.cmd == CMD_NORM) && ($urandom_range(19) != 0);
      op.av = ($urandom_range(9) != 0);
      op.bv = ($urandom_range(9) != 0);
      op.an = pick_value(narrow);
      op.bn = pick_value(narrow);
      op.ad = pick_value(narrow);
      op.bd = pick_value(narrow);
      if ($urandom_range(9) != 0) op.ad[31] = 1'b0;
      if ($urandom_range(9) != 0) op.bd[31] = 1'b0;
      if (op.cmd == CMD_NORM && $urandom_range(3) != 0) op.an[31] = 1'b0;
      op.typed = 1'b0;
      op.want = EMPTY;
      return op;
   endfunction

   fraction_op directed_ops[] = '{
      '{CMD_NORM, 1, 6, 4, 0, 0, 0, 1, '{1'b1, 64'd3, 62'd2}},
      '{CMD_NORM, 0, 0, 5, 0, 0, 0, 1, '{1'b1, 64'd0, 62'd5}},
      '{CMD_NORM, 1, NEG1, 4, 1, 0, 0, 1, EMPTY},
      '{CMD_NORM, 1, 3, 0, 1, 0, 0, 1, EMPTY},
      '{CMD_NORM, 1, 3, NEG1, 1, 0, 0, 1, EMPTY},
      '{CMD_NORM, 1, MAXV, 1, 1, 0, 0, 1, '{1'b1, 64'h7fff_ffff, 62'd1}},
      '{CMD_NORM, 1, MAXV, MAXV, 1, 0, 0, 1, '{1'b1, 64'd1, 62'd1}},
      '{CMD_NORM, 1, 32'h7fff_fffe, 32'h4000_0000, 1, MINV, MINV, 0, EMPTY},
      '{CMD_ADD, 1, 1, 2, 1, 1, 3, 0, EMPTY},
      '{CMD_ADD, 0, 1, 2, 1, 1, 3, 1, EMPTY},
      '{CMD_ADD, 1, 1, 2, 1, NEG1, 3, 1, EMPTY},
      '{CMD_ADD, 1, 1, 2, 1, 1, 0, 1, EMPTY},
      '{CMD_ADD, 1, MINV, MAXV, 1, MINV, MAXV, 0, EMPTY},
      '{CMD_ADD, 1, MAXV, MAXV, 1, MAXV, MAXV, 0, EMPTY},
      '{CMD_ADD, 1, 1, 1, 1, 32'hffff_fffe, 1, 1, EMPTY},
      '{CMD_ADDI, 1, 1, 2, 0, 3, 0, 0, EMPTY},
      '{CMD_ADDI, 1, 1, 2, 1, NEG1, 7, 1, EMPTY},
      '{CMD_ADDI, 1, 1, 32'hffff_fffb, 1, 3, 1, 1, EMPTY},
      '{CMD_ADDI, 1, MINV, MAXV, 0, MINV, MINV, 0, EMPTY},
      '{CMD_ADDI, 1, 1, 1, 1, 32'hffff_fffe, 1, 1, EMPTY},
      '{CMD_MUL, 1, 2, 3, 1, 5, 7, 1, '{1'b1, 64'd10, 62'd21}},
      '{CMD_MUL, 1, NEG1, 3, 1, 5, 7, 1, EMPTY},
      '{CMD_MUL, 1, 2, 3, 0, 5, 7, 1, EMPTY},
      '{CMD_MUL, 1, MINV, MAXV, 1, MINV, MAXV, 0, EMPTY}
   };

   initial begin
      int idle_plan[4] = '{0, 58, 0, 17};
      int stall_plan[4] = '{0, 0, 58, 17};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_ops[i]) send_op(directed_ops[i]);
      // hold off until the block is empty
      drain_results();
      for (int ph = 0; ph < 4; ph++) begin
         sender_idle_pct = idle_plan[ph];
         stall_pct = stall_plan[ph];
         for (int n = 0; n < 385; n++) send_op(random_op());
      end
      drain_results();
      repeat (100) @(posedge clock);
      $display("Covered %0d normalise, %0d add, %0d add-integer, %0d multiply transactions;",
         cmd_count[CMD_NORM], cmd_count[CMD_ADD], cmd_count[CMD_ADDI], cmd_count[CMD_MUL]);
      $display("%0d responses checked, %0d of them empty.", result_count, empty_count);
      if (failures == 0 && pending_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #200_000_000;
      $display("TEST FAILED");
      $finish;
   end
endmodule
